FILE: design/lrutc_pkg.sv
// Shared types and constants for the LRU tag cache manager.
// Used by lrutc_scan_step and lru_tag_cache_manager; depends on nothing else.
package lrutc_pkg;

    // Geometry
    localparam int CACHE_SLOTS  = 8;
    localparam int SLOT_W       = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
    localparam int KEY_W        = 21;
    localparam int STATUS_W     = 2;
    localparam int STAMP_W      = 32;
    localparam int SLOT_FIELD_W = 3;

    // Fill outcome codes
    localparam logic [STATUS_W-1:0] FILL_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] FILL_UNTOUCHED = 2'd1;
    localparam logic [STATUS_W-1:0] FILL_MIDWAY    = 2'd2;

    typedef logic [SLOT_W-1:0]  slot_idx_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [STAMP_W-1:0] stamp_t;

    // Request beat
    typedef struct packed {
        key_t                key;
        logic [STATUS_W-1:0] fill_status;
    } req_t;

    // Response beat
    typedef struct packed {
        logic                    ok;
        logic                    hit;
        logic [SLOT_FIELD_W-1:0] slot;
    } rsp_t;

    // Running result of the slot scan
    typedef struct packed {
        logic      hit_found;
        slot_idx_t hit_idx;
        logic      inv_found;
        slot_idx_t inv_idx;
        slot_idx_t best_idx;
        stamp_t    oldest;
    } scan_t;

endpackage

FILE: design/lrutc_scan_step.sv
// One step of the slot scan: key match, free-slot search and oldest-stamp compare
// for a single slot. Depends on lrutc_pkg.
module lrutc_scan_step
    import lrutc_pkg::*;
(
    input  slot_idx_t idx,
    input  logic      first,
    input  logic      entry_valid,
    input  key_t      entry_key,
    input  stamp_t    entry_stamp,
    input  key_t      key,
    input  scan_t     acc,
    output scan_t     nxt
);

    scan_t base;

    // Start fresh on slot zero, otherwise carry the running result
    always_comb
    begin
        if (first)
        begin
            base.hit_found = 1'b0;
            base.hit_idx   = '0;
            base.inv_found = 1'b0;
            base.inv_idx   = '0;
            base.best_idx  = '0;
            base.oldest    = entry_stamp;
        end
        else
        begin
            base = acc;
        end
    end

    // Fold this slot into the result
    always_comb
    begin
        nxt = base;
        // keep the first matching slot
        if (!base.hit_found && entry_valid && (entry_key == key))
        begin
            nxt.hit_found = 1'b1;
            nxt.hit_idx   = idx;
        end
        // first free slot among slots one and up
        if (!first && !entry_valid && !base.inv_found)
        begin
            nxt.inv_found = 1'b1;
            nxt.inv_idx   = idx;
        end
        // strictly smaller stamp wins, so ties keep the lower index
        if (!first && (entry_stamp < base.oldest))
        begin
            nxt.oldest   = entry_stamp;
            nxt.best_idx = idx;
        end
    end

endmodule

FILE: design/lru_tag_cache_manager.sv
// Top level of the fully associative LRU tag cache manager.
// Depends on lrutc_pkg and lrutc_scan_step.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------------------------
//  req      | in        | req_valid/req_stall  | req_t: key, fill_status
//  rsp      | out       | rsp_valid/rsp_stall  | rsp_t: ok, hit, slot
//
// From accept, the scan takes each slot in turn through the shared scan
// step, then an update state writes the tag store and loads the response
// register. req_stall is high from accept until the update commits, so a
// new request is taken only after the previous one has committed; the
// update waits while a response is stalled.
// rst_n clears the tag store, the use counter and all handshake state at once.
module lru_tag_cache_manager
    import lrutc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    localparam int IDX_EXT_W = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
    localparam slot_idx_t LAST_IDX = SLOT_W'(CACHE_SLOTS - 1);

    logic [1:0]              state_reg, state_next;
    slot_idx_t               scan_idx_reg, scan_idx_next;
    scan_t                   acc_reg, acc_next;
    req_t                    req_reg, req_next;
    logic [CACHE_SLOTS-1:0]  slot_valid_reg, slot_valid_next;
    key_t                    slot_key_reg [CACHE_SLOTS];
    stamp_t                  slot_stamp_reg [CACHE_SLOTS];
    stamp_t                  use_counter_reg, use_counter_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    scan_t                   step_out;
    slot_idx_t               victim;
    stamp_t                  count_inc;
    logic                    out_free;
    logic                    commit;
    logic                    key_we;
    logic                    stamp_we;
    logic [IDX_EXT_W-1:0]    victim_ext;

    // Shared scan step on the slot under the scan pointer
    lrutc_scan_step u_scan_step (
        .idx         (scan_idx_reg),
        .first       (scan_idx_reg == '0),
        .entry_valid (slot_valid_reg[scan_idx_reg]),
        .entry_key   (slot_key_reg[scan_idx_reg]),
        .entry_stamp (slot_stamp_reg[scan_idx_reg]),
        .key         (req_reg.key),
        .acc         (acc_reg),
        .nxt         (step_out)
    );

    // Pick the slot to use or replace
    always_comb
    begin
        if (acc_reg.hit_found)
            victim = acc_reg.hit_idx;
        else if (acc_reg.inv_found)
            victim = acc_reg.inv_idx;
        else if (!slot_valid_reg[0])
            victim = '0;
        else
            victim = acc_reg.best_idx;
    end

    assign count_inc  = use_counter_reg + 32'd1;
    assign victim_ext = IDX_EXT_W'(victim);
    assign out_free   = !rsp_valid_reg || !rsp_stall;
    assign commit     = (state_reg == ST_UPDATE) && out_free;

    // Sequencer and update
    always_comb
    begin
        state_next       = state_reg;
        scan_idx_next    = scan_idx_reg;
        acc_next         = acc_reg;
        req_next         = req_reg;
        slot_valid_next  = slot_valid_reg;
        use_counter_next = use_counter_reg;
        rsp_next         = rsp_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        key_we           = 1'b0;
        stamp_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next      = req;
                    scan_idx_next = '0;
                    state_next    = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                acc_next = step_out;
                if (scan_idx_reg == LAST_IDX)
                    state_next = ST_UPDATE;
                else
                    scan_idx_next = scan_idx_reg + 1'b1;
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    rsp_next.hit   = acc_reg.hit_found;
                    rsp_next.ok    = acc_reg.hit_found || (req_reg.fill_status == FILL_OK);
                    rsp_next.slot  = victim_ext[SLOT_FIELD_W-1:0];
                    rsp_valid_next = 1'b1;
                    if (acc_reg.hit_found)
                    begin
                        stamp_we = 1'b1;
                    end
                    else
                    begin
                        case (req_reg.fill_status)
                            FILL_OK:
                            begin
                                key_we                  = 1'b1;
                                stamp_we                = 1'b1;
                                slot_valid_next[victim] = 1'b1;
                            end
                            FILL_MIDWAY:
                            begin
                                slot_valid_next[victim] = 1'b0;
                            end
                            FILL_UNTOUCHED:
                            begin
                                slot_valid_next = slot_valid_reg;
                            end
                            default:
                            begin
                                slot_valid_next = slot_valid_reg;
                            end
                        endcase
                    end
                    if (stamp_we)
                        use_counter_next = count_inc;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            scan_idx_reg    <= '0;
            slot_valid_reg  <= '0;
            use_counter_reg <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            scan_idx_reg    <= scan_idx_next;
            slot_valid_reg  <= slot_valid_next;
            use_counter_reg <= use_counter_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    // Tag and stamp store, cleared to zero at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CACHE_SLOTS; i++)
            begin
                slot_key_reg[i]   <= '0;
                slot_stamp_reg[i] <= '0;
            end
        end
        else
        begin
            if (key_we)
                slot_key_reg[victim] <= req_reg.key;
            if (stamp_we)
                slot_stamp_reg[victim] <= count_inc;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        req_reg <= req_next;
        rsp_reg <= rsp_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // A hit is always resident
    a_hit_implies_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_reg.hit || rsp_reg.ok))
        else $error("response reports hit without ok");

    // The use counter moves by exactly one, and only on a commit
    a_counter_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(use_counter_reg) |-> (use_counter_reg == $past(use_counter_reg) + 32'd1)
                                      && ($past(commit)))
        else $error("use counter moved by other than one step");

    // An accepted request starts the scan at slot zero
    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (state_reg == ST_SCAN) && (scan_idx_reg == '0))
        else $error("accepted request did not start a scan");

    // A waiting response is never overwritten
    a_rsp_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> rsp_valid_reg && $stable(rsp_reg))
        else $error("stalled response was overwritten");

    // The valid set only changes when an update commits
    a_valid_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(slot_valid_reg) |-> $past(commit))
        else $error("slot valid bits changed outside an update");

endmodule
